>>> rtl/d2i_pkg.sv
// Package with the beat types and field constants of the double to integer converter.
`default_nettype none
package d2i_pkg;

	localparam int DBL_WIDTH = 64;
	localparam int FRAC_BITS = 52;
	localparam int EXP_BITS  = 11;
	localparam int MANT_BITS = FRAC_BITS + 1;
	localparam int RES_WIDTH = 64;
	localparam int INT_WIDTH_DEFAULT = 64;

	localparam logic [EXP_BITS-1:0] EXP_MAX = 11'h7FF;
	localparam logic [EXP_BITS-1:0] EXP_ZERO = 11'h000;
	// Exponent at which the mantissa's lowest bit weighs one.
	localparam logic [EXP_BITS-1:0] EXP_UNIT = 11'd1075;
	// Largest exponent whose value can still fit in 64 bits.
	localparam logic [EXP_BITS-1:0] EXP_TOP = 11'd1086;
	// Right shifts of this size or more leave nothing of the mantissa.
	localparam logic [EXP_BITS-1:0] SHIFT_GONE = 11'd54;

	typedef struct packed {
		logic [DBL_WIDTH-1:0]        value_bits;
		logic                        round_toward_zero;
		logic signed [RES_WIDTH-1:0] fallback_value;
	} operand_t;

	typedef struct packed {
		logic signed [RES_WIDTH-1:0] integer_result;
		logic                        in_range;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/double_to_int64_converter.sv
// Top level of the binary64 to signed integer converter with input and result registers.
//
//   channel   signals              meaning
//   input     start, busy, operand one beat is taken when start is high and busy is low
//   output    done, result         done marks the single cycle a result beat is shown
//
// Each beat passes from acceptance through the input register, then through the conversion
// logic into the result register, before done is raised. A new beat is taken every cycle.
// busy is always low, and the receiver cannot stall, so results leave in order unblocked.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none
module double_to_int64_converter #(
	parameter int INT_WIDTH = d2i_pkg::INT_WIDTH_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire d2i_pkg::operand_t operand,
	output logic                   done,
	output d2i_pkg::result_t       result
);
	import d2i_pkg::*;

	operand_t operand_s1;
	logic     valid_s1;
	result_t  conv;
	result_t  result_s2;
	logic     valid_s2;

	assign busy = 1'b0;

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			operand_s1 <= operand;
		end
		if (valid_s1) begin
			result_s2 <= conv;
		end
	end

	d2i_core #(
		.INT_WIDTH(INT_WIDTH)
	) u_core (
		.operand(operand_s1),
		.result (conv)
	);

	assign done   = valid_s2;
	assign result = result_s2;

endmodule
`default_nettype wire

>>> rtl/d2i_core.sv
// Combinational conversion of one binary64 pattern to a rounded signed integer.
`default_nettype none
module d2i_core #(
	parameter int INT_WIDTH = d2i_pkg::INT_WIDTH_DEFAULT
) (
	input  wire d2i_pkg::operand_t operand,
	output d2i_pkg::result_t       result
);
	import d2i_pkg::*;

	logic                 sign;
	logic [EXP_BITS-1:0]  ex;
	logic [FRAC_BITS-1:0] frac;
	logic [MANT_BITS-1:0] mant;
	logic [EXP_BITS-1:0]  shl_full;
	logic [EXP_BITS-1:0]  shr_full;
	logic [MANT_BITS:0]   shifted;
	logic [RES_WIDTH-1:0] mag;
	logic [RES_WIDTH-1:0] limit;
	logic                 too_big;
	logic                 fits;

	// Split the pattern into its fields.
	assign sign     = operand.value_bits[DBL_WIDTH-1];
	assign ex       = operand.value_bits[DBL_WIDTH-2 -: EXP_BITS];
	assign frac     = operand.value_bits[FRAC_BITS-1:0];
	assign mant     = {1'b1, frac};
	assign shl_full = ex - EXP_UNIT;
	assign shr_full = EXP_UNIT - ex;
	assign shifted  = {mant, 1'b0} >> shr_full[5:0];
	assign limit    = RES_WIDTH'(1) << (INT_WIDTH - 1);

	// Magnitude after scaling and rounding; the lowest bit of the right shift is the half bit.
	always_comb begin
		too_big = 1'b0;
		if (ex >= EXP_UNIT) begin
			too_big = (ex > EXP_TOP) || ((ex == EXP_TOP) && (frac != '0));
			mag = RES_WIDTH'(mant) << shl_full[3:0];
		end else if (shr_full >= SHIFT_GONE) begin
			mag = '0;
		end else begin
			mag = RES_WIDTH'(shifted[MANT_BITS:1])
				+ RES_WIDTH'(!operand.round_toward_zero && shifted[0]);
		end
	end

	assign fits = sign ? (mag <= limit) : (mag < limit);

	// Choose between the special cases, the converted value and the fallback.
	always_comb begin
		if (ex == EXP_MAX || too_big || (ex != EXP_ZERO && !fits)) begin
			result.integer_result = operand.fallback_value;
			result.in_range       = 1'b0;
		end else if (ex == EXP_ZERO) begin
			result.integer_result = '0;
			result.in_range       = 1'b1;
		end else begin
			result.integer_result = sign ? -mag : mag;
			result.in_range       = 1'b1;
		end
	end

endmodule
`default_nettype wire
